// ----- hdl/cv3_pkg.sv -----
`default_nettype none

package cv3_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned MASK_SIZE      = 3;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LINE_W     = 2 * PIX_W;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned COEF_ROW_W = MASK_SIZE * PIX_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [DIM_W-1:0]      FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST     = 24'h0100FF;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST     = 24'h0200FE;
  localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RST  = 24'h0100FF;
  localparam logic [PIX_W-1:0]      PIX_MAX          = 8'd255;

  // 9x8 signed product, sum of three, sum of nine
  localparam int unsigned PROD_W    = 17;
  localparam int unsigned ROW_SUM_W = 19;
  localparam int unsigned SUM_W     = 21;

  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4
  } cv3_reg_e;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_in;
  } cv3_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } cv3_out_t;

  // [row][column], row 0 on top, column 0 on the left
  typedef logic [MASK_SIZE-1:0][MASK_SIZE-1:0][PIX_W-1:0] cv3_view_t;
  typedef logic [MASK_SIZE-1:0][COEF_ROW_W-1:0]            cv3_coef_t;

  typedef struct packed {
    logic             first;
    logic             emit;
    logic             last;
    logic             top_z;
    logic             bot_z;
    logic             left_z;
    logic             right_z;
    logic [PIX_W-1:0] pix;
  } cv3_item_t;

endpackage

`default_nettype wire

// ----- hdl/cv3_line_mem.sv -----
`default_nettype none

module cv3_line_mem
  import cv3_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  parameter int unsigned AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [LINE_W-1:0] wdata_i,
  output logic [LINE_W-1:0] rdata_o
);

  logic [LINE_W-1:0] mem_q [DEPTH];
  logic [LINE_W-1:0] rdata_q;

  // a read of the entry being written in the same cycle returns the new word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/cv3_window.sv -----
`default_nettype none

module cv3_window
  import cv3_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cv3_item_t        item_i,
  input  logic [PIX_W-1:0] above_i,
  input  logic [PIX_W-1:0] mid_i,
  input  logic             clear_i,
  output logic             view_valid_o,
  output logic             view_last_o,
  output cv3_view_t        view_o
);

  cv3_view_t                          win_q, win_d;
  cv3_view_t                          view_d, view_q;
  logic                               view_valid_q;
  logic                               view_last_q;
  logic [MASK_SIZE-1:0][PIX_W-1:0]    col_new;

  always_comb begin
    col_new[0] = above_i;
    col_new[1] = mid_i;
    col_new[2] = item_i.pix;

    // a word in the first column centres the last column: view the previous window moved left
    for (int r = 0; r < MASK_SIZE; r++) begin
      view_d[r][0] = item_i.left_z ? '0 : win_q[r][1];
      view_d[r][1] = win_q[r][2];
      view_d[r][2] = (item_i.first || item_i.right_z) ? '0 : col_new[r];
    end
    if (item_i.top_z) begin
      view_d[0] = '0;
    end
    if (item_i.bot_z) begin
      view_d[MASK_SIZE-1] = '0;
    end

    win_d = win_q;
    if (clear_i) begin
      win_d = '0;
    end else if (valid_i) begin
      if (item_i.last) begin
        win_d = '0;
      end else begin
        for (int r = 0; r < MASK_SIZE; r++) begin
          win_d[r][0] = win_q[r][1];
          win_d[r][1] = win_q[r][2];
          win_d[r][2] = col_new[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      view_valid_q <= 1'b0;
    end else begin
      win_q        <= win_d;
      view_valid_q <= valid_i && item_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    view_q      <= view_d;
    view_last_q <= item_i.last;
  end

  assign view_valid_o = view_valid_q;
  assign view_last_o  = view_last_q;
  assign view_o       = view_q;

endmodule

`default_nettype wire

// ----- hdl/cv3_mac.sv -----
`default_nettype none

module cv3_mac
  import cv3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       last_i,
  input  cv3_view_t  view_i,
  input  cv3_coef_t  coef_i,
  output logic       push_o,
  output cv3_out_t   push_data_o,
  output logic [1:0] busy_o
);

  logic signed [PROD_W-1:0]    prod_q [MASK_SIZE][MASK_SIZE];
  logic signed [ROW_SUM_W-1:0] rsum_q [MASK_SIZE];
  logic signed [SUM_W-1:0]     total;
  logic                        prod_valid_q, rsum_valid_q;
  logic                        prod_last_q, rsum_last_q;
  logic [PIX_W-1:0]            clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      rsum_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      rsum_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < MASK_SIZE; r++) begin
      for (int k = 0; k < MASK_SIZE; k++) begin
        prod_q[r][k] <= PROD_W'($signed({1'b0, view_i[r][k]})
                        * $signed(coef_i[r][PIX_W*k +: PIX_W]));
      end
      rsum_q[r] <= ROW_SUM_W'(prod_q[r][0]) + ROW_SUM_W'(prod_q[r][1])
                   + ROW_SUM_W'(prod_q[r][2]);
    end
    prod_last_q <= last_i;
    rsum_last_q <= prod_last_q;
  end

  always_comb begin
    total = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
    // negative clamps to zero, anything above a byte to full scale
    if (total[SUM_W-1]) begin
      clamped = '0;
    end else if (|total[SUM_W-2:PIX_W]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = total[PIX_W-1:0];
    end
  end

  assign push_o                 = rsum_valid_q;
  assign push_data_o.pixel_out  = clamped;
  assign push_data_o.frame_last = rsum_last_q;
  assign busy_o                 = 2'(prod_valid_q) + 2'(rsum_valid_q);

endmodule

`default_nettype wire

// ----- hdl/cv3_out_fifo.sv -----
`default_nettype none

module cv3_out_fifo
  import cv3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cv3_out_t             push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cv3_out_t             out_data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  cv3_out_t             mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign pop = (cnt_q != '0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

// ----- hdl/conv3x3_clamp_stream.sv -----
// Path: the input word completing its window (frame_width+1 words after its centre pixel)
//   passes through the s1, window, product and row-sum registers into the output FIFO.
// Throughput: one word per cycle while in_stall_o is low; the line store is read at accept
//   and written back in the next cycle, with write-to-read bypass for single-column frames.
// Reset: counters, window and registers return to defaults; line stores are not cleared.
`default_nettype none

module conv3x3_clamp_stream
  import cv3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cv3_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cv3_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OW = OUT_CNT_W + 1;

  logic [DIM_W-1:0]     fw_q, fh_q;
  cv3_coef_t            coef_q;
  logic [WW-1:0]        eff_w;
  logic [RW-1:0]        eff_h;
  logic                 cfg_restart;

  logic [AW-1:0]        in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]        in_row_q, in_row_d, out_row_q, out_row_d;
  logic [WW-1:0]        in_col_nx, out_col_nx;
  logic                 in_col_wrap, out_col_end, out_row_end;
  logic                 in_acc, flush, skip, go;
  cv3_item_t            item_d, s1_item_q;
  logic                 s1_valid_q;
  logic [AW-1:0]        s1_col_q;

  logic [LINE_W-1:0]    rd_word;
  logic                 view_valid, view_last;
  cv3_view_t            view;
  logic                 push;
  cv3_out_t             push_data;
  logic [1:0]           mac_busy;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [OW-1:0]        outstanding;

  always_comb begin
    if (fw_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_q);
    end
    if (fh_q == '0) begin
      eff_h = RW'(1);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(fh_q);
    end
  end

  assign cfg_restart = cfg_we_i && ((cfg_idx_i == REG_FRAME_WIDTH)
                                 || (cfg_idx_i == REG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= FRAME_WIDTH_RST;
      fh_q      <= FRAME_HEIGHT_RST;
      coef_q[0] <= COEF_TOP_RST;
      coef_q[1] <= COEF_MID_RST;
      coef_q[2] <= COEF_BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q      <= cfg_wdata_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_q      <= cfg_wdata_i[DIM_W-1:0];
        REG_COEF_TOP:     coef_q[0] <= cfg_wdata_i[COEF_ROW_W-1:0];
        REG_COEF_MID:     coef_q[1] <= cfg_wdata_i[COEF_ROW_W-1:0];
        REG_COEF_BOTTOM:  coef_q[2] <= cfg_wdata_i[COEF_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // stream position, advanced at accept so back-to-back words see it at once
  always_comb begin
    in_acc      = in_valid_i && !in_stall_o;
    flush       = in_data_i.mode;
    skip        = flush && (in_col_q == '0) && (in_row_q == '0);
    go          = in_acc && !skip;
    in_col_nx   = WW'(in_col_q) + WW'(1);
    in_col_wrap = in_col_nx >= eff_w;
    out_col_nx  = WW'(out_col_q) + WW'(1);
    out_col_end = out_col_nx >= eff_w;
    out_row_end = (out_row_q + RW'(1)) >= eff_h;

    item_d.first   = (in_col_q == '0);
    item_d.emit    = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
    item_d.last    = item_d.emit && out_row_end && out_col_end;
    item_d.top_z   = (out_row_q == '0);
    item_d.bot_z   = out_row_end;
    item_d.left_z  = (out_col_q == '0);
    item_d.right_z = out_col_end;
    item_d.pix     = (flush || (in_row_q >= eff_h)) ? '0 : in_data_i.pixel_in;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (go) begin
      if (item_d.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_col_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_nx[AW-1:0];
        end
        if (item_d.emit) begin
          if (out_col_end) begin
            out_col_d = '0;
            out_row_d = out_row_q + RW'(1);
          end else begin
            out_col_d = out_col_nx[AW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      s1_valid_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_d;
    s1_col_q  <= in_col_q;
  end

  // word layout: upper byte two rows up, lower byte one row up
  cv3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (go),
    .raddr_i (in_col_q),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i ({rd_word[PIX_W-1:0], s1_item_q.pix}),
    .rdata_o (rd_word)
  );

  cv3_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid_q),
    .item_i       (s1_item_q),
    .above_i      (rd_word[LINE_W-1:PIX_W]),
    .mid_i        (rd_word[PIX_W-1:0]),
    .clear_i      (cfg_restart),
    .view_valid_o (view_valid),
    .view_last_o  (view_last),
    .view_o       (view)
  );

  cv3_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (view_valid),
    .last_i      (view_last),
    .view_i      (view),
    .coef_i      (coef_q),
    .push_o      (push),
    .push_data_o (push_data),
    .busy_o      (mac_busy)
  );

  cv3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_cnt)
  );

  // hold input while every result in flight might still need a FIFO slot
  assign outstanding = OW'(fifo_cnt) + OW'(s1_valid_q && s1_item_q.emit)
                       + OW'(view_valid) + OW'(mac_busy);
  assign in_stall_o  = outstanding >= OW'(OUT_DEPTH);

`ifndef SYNTHESIS
  a_fifo_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding <= OW'(OUT_DEPTH))
    else $error("results in flight exceed output FIFO depth");

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < eff_w)
    else $error("input column beyond frame width");

  a_out_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q < eff_h)
    else $error("output row beyond frame height");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && item_d.last) |=> ((in_col_q == '0) && (in_row_q == '0)
                             && (out_col_q == '0) && (out_row_q == '0)))
    else $error("stream position not cleared after final word of frame");
`endif

endmodule

`default_nettype wire
